/* hw/rtl/rv32_pkg.sv */
// ----------------------------------------------------------------------------
// rv32_pkg
// Shared types and codes for the RV32I execute block.
// ----------------------------------------------------------------------------
package rv32_pkg;

    localparam int REG_COUNT_DEF = 32;
    localparam int XLEN          = 32;

    localparam logic [6:0] OPC_LOAD   = 7'b00_000_11;
    localparam logic [6:0] OPC_MISC   = 7'b00_011_11;
    localparam logic [6:0] OPC_OPIMM  = 7'b00_100_11;
    localparam logic [6:0] OPC_AUIPC  = 7'b00_101_11;
    localparam logic [6:0] OPC_STORE  = 7'b01_000_11;
    localparam logic [6:0] OPC_OP     = 7'b01_100_11;
    localparam logic [6:0] OPC_LUI    = 7'b01_101_11;
    localparam logic [6:0] OPC_BRANCH = 7'b11_000_11;
    localparam logic [6:0] OPC_JALR   = 7'b11_001_11;
    localparam logic [6:0] OPC_JAL    = 7'b11_011_11;
    localparam logic [6:0] OPC_SYSTEM = 7'b11_100_11;
    localparam logic [6:0] F7_ALT     = 7'b010_0000;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_UNSUP  = 3'd1;
    localparam logic [2:0] ST_BUSERR = 3'd2;
    localparam logic [2:0] ST_BUSY   = 3'd3;
    localparam logic [2:0] ST_UNEXP  = 3'd4;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_ECALL  = 2'd1;
    localparam logic [1:0] EV_EBREAK = 2'd2;
    localparam logic [1:0] EV_FENCE  = 2'd3;

    localparam logic [1:0] MR_NONE  = 2'd0;
    localparam logic [1:0] MR_READ  = 2'd1;
    localparam logic [1:0] MR_WRITE = 2'd2;

    typedef struct packed {
        logic [31:0] dest_value;
        logic [4:0]  dest_index;
        logic        reg_written;
        logic [31:0] mem_write_data;
        logic [2:0]  mem_bytes;
        logic [31:0] mem_address;
        logic [1:0]  mem_request;
        logic [31:0] next_pc;
        logic [1:0]  event_kind;
        logic [2:0]  status;
    } result_t;

endpackage

/* hw/rtl/rv32_ram.sv */
// ----------------------------------------------------------------------------
// rv32_ram
// Generic synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rv32_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* hw/rtl/rv32i_instruction_execute_top.sv */
// RV32I execute block.
// The input transaction is registered into stage 1 (register file read), then executed
// into the output register. Throughput: one item per cycle unless the output stalls;
// a stalled result holds the input. Results written back are forwarded to the
// following item, also while it waits on a stall.
// Reset: pc = 0, no load pending, all registers read as zero via per-entry valid bits.
// ----------------------------------------------------------------------------
// rv32i_instruction_execute_top
// Two-stage executor: RAM read stage, execute stage with output register.
// ----------------------------------------------------------------------------
module rv32i_instruction_execute_top #(
    parameter int REG_COUNT = rv32_pkg::REG_COUNT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: instruction[31:0], load_data[63:32], bus_error[64], zero fill
    input  logic [71:0]  s_tdata,
    // tuser: operation
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status, event_kind, next_pc, mem_request, mem_address, mem_bytes,
    //        mem_write_data, reg_written, dest_index, dest_value
    output logic [143:0] m_tdata
);
    import rv32_pkg::*;

    localparam int RW = $clog2(REG_COUNT);

    logic         s1_v_reg, s1_v_next;
    logic         s1_op_reg;
    logic [31:0]  s1_inst_reg, s1_ld_reg;
    logic         s1_be_reg;
    logic [31:0]  ra_raw, rb_raw;
    logic [REG_COUNT-1:0] rv_reg;
    logic [31:0]  pc_reg;
    logic         lp_reg;
    logic [4:0]   ld_reg;
    logic [2:0]   lk_reg;
    logic         ov_reg;
    result_t      o_reg, res;
    logic         adv;
    logic         wb_we, fw_v_reg;
    logic [4:0]   fw_i_reg;
    logic [31:0]  fw_d_reg;
    logic [4:0]   rs1_in, rs2_in;

    assign rs1_in = s_tdata[19:15];
    assign rs2_in = s_tdata[24:20];

    assign adv      = !ov_reg || m_tready;
    assign s_tready = adv;
    assign s1_v_next = s_tvalid && s_tready;

    rv32_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_ra (
        .clk(clk), .we(wb_we), .waddr(res.dest_index[RW-1:0]), .wdata(res.dest_value),
        .re(s1_v_next), .raddr(rs1_in[RW-1:0]), .rdata(ra_raw));
    rv32_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rb (
        .clk(clk), .we(wb_we), .waddr(res.dest_index[RW-1:0]), .wdata(res.dest_value),
        .re(s1_v_next), .raddr(rs2_in[RW-1:0]), .rdata(rb_raw));

    // stage 1 operand fix-up: valid bits, x0, forwarding of the item just retired
    logic [31:0] a, b;
    logic [4:0]  rs1, rs2, rd;
    logic [2:0]  f3;
    logic [6:0]  opc, f7;

    always_comb
    begin
        opc = s1_inst_reg[6:0];
        rd  = s1_inst_reg[11:7];
        f3  = s1_inst_reg[14:12];
        rs1 = s1_inst_reg[19:15];
        rs2 = s1_inst_reg[24:20];
        f7  = s1_inst_reg[31:25];
        a = (rs1 == 5'd0 || 32'(rs1) >= REG_COUNT || !rv_reg[rs1[RW-1:0]]) ? 32'd0 : ra_raw;
        b = (rs2 == 5'd0 || 32'(rs2) >= REG_COUNT || !rv_reg[rs2[RW-1:0]]) ? 32'd0 : rb_raw;
        if (fw_v_reg && fw_i_reg == rs1)
        begin
            a = fw_d_reg;
        end
        if (fw_v_reg && fw_i_reg == rs2)
        begin
            b = fw_d_reg;
        end
    end

    function automatic logic iok(input logic [4:0] i);
        iok = 32'(i) < REG_COUNT;
    endfunction

    logic [31:0] immI, immS, immB, immJ, wval, npc, sum;
    logic        ok, wr, tk;
    logic [4:0]  sh;

    always_comb
    begin
        immI = {{20{s1_inst_reg[31]}}, s1_inst_reg[31:20]};
        immS = {{20{s1_inst_reg[31]}}, s1_inst_reg[31:25], s1_inst_reg[11:7]};
        immB = {{19{s1_inst_reg[31]}}, s1_inst_reg[31], s1_inst_reg[7],
                s1_inst_reg[30:25], s1_inst_reg[11:8], 1'b0};
        immJ = {{11{s1_inst_reg[31]}}, s1_inst_reg[31], s1_inst_reg[19:12],
                s1_inst_reg[20], s1_inst_reg[30:21], 1'b0};
        sh   = b[4:0];
        res  = '0;
        res.next_pc = pc_reg;
        ok = 1'b1; wr = 1'b0; tk = 1'b0; wval = '0;
        npc = pc_reg + 32'd4;
        sum = '0;
        if (s1_op_reg)
        begin
            if (!lp_reg)
            begin
                res.status = ST_UNEXP;
            end
            else if (s1_be_reg)
            begin
                res.status = ST_BUSERR;
            end
            else
            begin
                unique case (lk_reg)
                    3'd0:    wval = {{24{s1_ld_reg[7]}}, s1_ld_reg[7:0]};
                    3'd1:    wval = {{16{s1_ld_reg[15]}}, s1_ld_reg[15:0]};
                    3'd4:    wval = {24'd0, s1_ld_reg[7:0]};
                    3'd5:    wval = {16'd0, s1_ld_reg[15:0]};
                    default: wval = s1_ld_reg;
                endcase
                if (ld_reg != 5'd0)
                begin
                    res.reg_written = 1'b1;
                    res.dest_index  = ld_reg;
                    res.dest_value  = wval;
                end
            end
        end
        else if (lp_reg)
        begin
            res.status = ST_BUSY;
        end
        else
        begin
            unique case (opc)
                OPC_LOAD:
                begin
                    ok = (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2 || f3 == 3'd4 || f3 == 3'd5)
                         && iok(rd) && iok(rs1);
                    res.mem_request = MR_READ;
                    res.mem_address = a + immI;
                    res.mem_bytes   = (f3[1:0] == 2'd0) ? 3'd1 : (f3[1:0] == 2'd1) ? 3'd2 : 3'd4;
                end
                OPC_MISC:
                begin
                    ok = (f3 == 3'd0);
                    res.event_kind = EV_FENCE;
                end
                OPC_OPIMM:
                begin
                    ok = iok(rd) && iok(rs1);
                    wr = 1'b1;
                    unique case (f3)
                        3'd0: wval = a + immI;
                        3'd2: wval = {31'd0, $signed(a) < $signed(immI)};
                        3'd3: wval = {31'd0, a < immI};
                        3'd4: wval = a ^ immI;
                        3'd6: wval = a | immI;
                        3'd7: wval = a & immI;
                        default: ok = 1'b0;
                    endcase
                end
                OPC_AUIPC:
                begin
                    ok = iok(rd); wr = 1'b1;
                    wval = pc_reg + {s1_inst_reg[31:12], 12'd0};
                end
                OPC_LUI:
                begin
                    ok = iok(rd); wr = 1'b1;
                    wval = {s1_inst_reg[31:12], 12'd0};
                end
                OPC_STORE:
                begin
                    ok = f3 <= 3'd2 && iok(rs1) && iok(rs2);
                    res.mem_request = MR_WRITE;
                    res.mem_address = a + immS;
                    res.mem_bytes   = (f3 == 3'd0) ? 3'd1 : (f3 == 3'd1) ? 3'd2 : 3'd4;
                    res.mem_write_data = (f3 == 3'd0) ? {24'd0, b[7:0]} :
                                         (f3 == 3'd1) ? {16'd0, b[15:0]} : b;
                end
                OPC_OP:
                begin
                    ok = iok(rd) && iok(rs1) && iok(rs2);
                    wr = 1'b1;
                    if (f7 == F7_ALT && f3 == 3'd0)
                    begin
                        wval = a - b;
                    end
                    else if (f7 == F7_ALT && f3 == 3'd5)
                    begin
                        wval = 32'($signed(a) >>> sh);
                    end
                    else if (f7 != 7'd0)
                    begin
                        ok = 1'b0;
                    end
                    else
                    begin
                        unique case (f3)
                            3'd0: wval = a + b;
                            3'd1: wval = a << sh;
                            3'd2: wval = {31'd0, $signed(a) < $signed(b)};
                            3'd3: wval = {31'd0, a < b};
                            3'd4: wval = a ^ b;
                            3'd5: wval = a >> sh;
                            3'd6: wval = a | b;
                            default: wval = a & b;
                        endcase
                    end
                end
                OPC_BRANCH:
                begin
                    ok = iok(rs1) && iok(rs2);
                    unique case (f3)
                        3'd0: tk = (a == b);
                        3'd1: tk = (a != b);
                        3'd4: tk = $signed(a) < $signed(b);
                        3'd5: tk = $signed(a) >= $signed(b);
                        3'd6: tk = a < b;
                        3'd7: tk = a >= b;
                        default: ok = 1'b0;
                    endcase
                    if (tk)
                    begin
                        npc = pc_reg + immB;
                    end
                end
                OPC_JALR:
                begin
                    ok = f3 == 3'd0 && iok(rd) && iok(rs1);
                    wr = 1'b1; wval = pc_reg + 32'd4;
                    sum = a + immI;
                    npc = {sum[31:1], 1'b0};
                end
                OPC_JAL:
                begin
                    ok = iok(rd); wr = 1'b1; wval = pc_reg + 32'd4;
                    npc = pc_reg + immJ;
                end
                OPC_SYSTEM:
                begin
                    if (f3 == 3'd0 && s1_inst_reg[31:20] == 12'd0)
                    begin
                        res.event_kind = EV_ECALL;
                    end
                    else if (f3 == 3'd0 && s1_inst_reg[31:20] == 12'd1)
                    begin
                        res.event_kind = EV_EBREAK;
                    end
                    else
                    begin
                        ok = 1'b0;
                    end
                end
                default: ok = 1'b0;
            endcase
            if (!ok)
            begin
                res = '0;
                res.status  = ST_UNSUP;
                res.next_pc = pc_reg;
            end
            else
            begin
                res.next_pc = npc;
                if (wr && rd != 5'd0)
                begin
                    res.reg_written = 1'b1;
                    res.dest_index  = rd;
                    res.dest_value  = wval;
                end
            end
        end
    end

    logic fire;
    assign fire  = s1_v_reg && adv;
    assign wb_we = fire && res.reg_written;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            ov_reg   <= 1'b0;
            rv_reg   <= '0;
            pc_reg   <= '0;
            lp_reg   <= 1'b0;
            ld_reg   <= '0;
            lk_reg   <= '0;
            fw_v_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_v_reg <= s1_v_next;
                ov_reg   <= s1_v_reg;
                fw_v_reg <= s1_v_next && wb_we;
            end
            if (wb_we)
            begin
                rv_reg[res.dest_index[RW-1:0]] <= 1'b1;
            end
            if (fire)
            begin
                if (s1_op_reg)
                begin
                    lp_reg <= 1'b0;
                end
                else if (res.status == ST_OK)
                begin
                    pc_reg <= res.next_pc;
                    if (res.mem_request == MR_READ)
                    begin
                        lp_reg <= 1'b1;
                        ld_reg <= rd;
                        lk_reg <= f3;
                    end
                end
            end
            if (cfg_we)
            begin
                pc_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_v_next)
        begin
            s1_op_reg   <= s_tuser;
            s1_inst_reg <= s_tdata[31:0];
            s1_ld_reg   <= s_tdata[63:32];
            s1_be_reg   <= s_tdata[64];
        end
        if (adv)
        begin
            fw_i_reg <= res.dest_index;
            fw_d_reg <= res.dest_value;
        end
        if (fire)
        begin
            o_reg <= res;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {o_reg.dest_value, o_reg.dest_index, o_reg.reg_written,
                       o_reg.mem_write_data, o_reg.mem_bytes, o_reg.mem_address,
                       o_reg.mem_request, o_reg.next_pc, o_reg.event_kind, o_reg.status};

`ifndef SYNTH
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped under stall");
    a_x0: assert property (@(posedge clk) disable iff (!rst_n)
        wb_we |-> res.dest_index != 5'd0)
        else $error("write to x0");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !s1_op_reg && lp_reg |-> res.status == ST_BUSY)
        else $error("execute ran with pending load");
`endif
endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// RV32I execute block testbench
// Drives random and directed instruction and load-return transactions through
// the stream input, predicts each result with an in-bench model of the
// register file, pc and pending load, and checks every output transaction
// field by field under several idle and stall patterns and start addresses.
// ----------------------------------------------------------------------------
module tb;
    import rv32_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        bus_error;
        logic [31:0] load_data;
        logic [31:0] instruction;
        logic        is_return;
    } cmd_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;

    rv32i_instruction_execute_top uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #5 clk = ~clk;

    cmd_t    pending_cmds[$];
    result_t expected_results[$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;

    logic [31:0] gpr[32];
    logic [31:0] pc_q;
    logic        ld_busy;
    logic [4:0]  ld_rd;
    logic [2:0]  ld_f3;

    function automatic logic [31:0] sext(logic [31:0] v, int bits);
        logic [31:0] m;
        m = 32'h1 << (bits - 1);
        v = v & ((m << 1) - 1);
        return (v ^ m) - m;
    endfunction

    function automatic logic [31:0] rreg(logic [4:0] i);
        return (i == 0) ? 32'h0 : gpr[i];
    endfunction

    function automatic logic lt_s(logic [31:0] a, logic [31:0] b);
        return (a ^ 32'h8000_0000) < (b ^ 32'h8000_0000);
    endfunction

    function automatic result_t execute_cmd(cmd_t c);
        result_t r;
        logic [31:0] ins, a, b, immi, imms, immb, immj, wval, npc, rdat;
        logic [6:0]  opc, f7;
        logic [4:0]  rd, rs1, rs2, sh;
        logic [2:0]  f3;
        logic        ok, wr, tk;
        r = '0;
        ins = c.instruction;
        opc = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12];
        rs1 = ins[19:15]; rs2 = ins[24:20]; f7 = ins[31:25];
        a = rreg(rs1); b = rreg(rs2);
        immi = sext({20'h0, ins[31:20]}, 12);
        imms = sext({20'h0, ins[31:25], ins[11:7]}, 12);
        immb = sext({19'h0, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
        immj = sext({11'h0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
        npc = pc_q; ok = 1'b1; wr = 1'b0; wval = '0; tk = 1'b0; sh = b[4:0];
        if (c.is_return) begin
            if (!ld_busy) r.status = ST_UNEXP;
            else begin
                ld_busy = 1'b0;
                if (c.bus_error) r.status = ST_BUSERR;
                else begin
                    rdat = c.load_data;
                    case (ld_f3)
                        3'd0: wval = sext(rdat, 8);
                        3'd1: wval = sext(rdat, 16);
                        3'd4: wval = rdat & 32'hff;
                        3'd5: wval = rdat & 32'hffff;
                        default: wval = rdat;
                    endcase
                    if (ld_rd != 0) begin
                        gpr[ld_rd] = wval;
                        r.reg_written = 1'b1; r.dest_index = ld_rd; r.dest_value = wval;
                    end
                end
            end
        end else if (ld_busy) r.status = ST_BUSY;
        else begin
            npc = pc_q + 4;
            case (opc)
                OPC_LOAD: begin
                    ok = f3 inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5};
                    if (ok) begin
                        r.mem_request = MR_READ; r.mem_address = a + immi;
                        r.mem_bytes = (f3[1:0] == 0) ? 3'd1 : (f3[1:0] == 1) ? 3'd2 : 3'd4;
                        ld_busy = 1'b1; ld_rd = rd; ld_f3 = f3;
                    end
                end
                OPC_MISC: begin ok = (f3 == 0); r.event_kind = EV_FENCE; end
                OPC_OPIMM: begin
                    wr = 1'b1;
                    case (f3)
                        3'd0: wval = a + immi;
                        3'd2: wval = {31'h0, lt_s(a, immi)};
                        3'd3: wval = {31'h0, a < immi};
                        3'd4: wval = a ^ immi;
                        3'd6: wval = a | immi;
                        3'd7: wval = a & immi;
                        default: ok = 1'b0;
                    endcase
                end
                OPC_AUIPC: begin wr = 1'b1; wval = pc_q + {ins[31:12], 12'h0}; end
                OPC_LUI: begin wr = 1'b1; wval = {ins[31:12], 12'h0}; end
                OPC_STORE: begin
                    ok = f3 <= 2;
                    if (ok) begin
                        r.mem_request = MR_WRITE; r.mem_address = a + imms;
                        r.mem_bytes = (f3 == 0) ? 3'd1 : (f3 == 1) ? 3'd2 : 3'd4;
                        r.mem_write_data = (f3 == 0) ? (b & 32'hff) :
                                           (f3 == 1) ? (b & 32'hffff) : b;
                    end
                end
                OPC_OP: begin
                    wr = 1'b1;
                    if (f7 == F7_ALT && f3 == 0) wval = a - b;
                    else if (f7 == F7_ALT && f3 == 5) wval = $signed(a) >>> sh;
                    else if (f7 != 0) ok = 1'b0;
                    else case (f3)
                        3'd0: wval = a + b;
                        3'd1: wval = a << sh;
                        3'd2: wval = {31'h0, lt_s(a, b)};
                        3'd3: wval = {31'h0, a < b};
                        3'd4: wval = a ^ b;
                        3'd5: wval = a >> sh;
                        3'd6: wval = a | b;
                        default: wval = a & b;
                    endcase
                end
                OPC_BRANCH: begin
                    case (f3)
                        3'd0: tk = a == b;
                        3'd1: tk = a != b;
                        3'd4: tk = lt_s(a, b);
                        3'd5: tk = !lt_s(a, b);
                        3'd6: tk = a < b;
                        3'd7: tk = a >= b;
                        default: ok = 1'b0;
                    endcase
                    if (tk) npc = pc_q + immb;
                end
                OPC_JALR: begin
                    ok = f3 == 0; wr = 1'b1; wval = pc_q + 4;
                    npc = (a + immi) & ~32'h1;
                end
                OPC_JAL: begin wr = 1'b1; wval = pc_q + 4; npc = pc_q + immj; end
                OPC_SYSTEM: begin
                    if (f3 == 0 && ins[31:20] == 0) r.event_kind = EV_ECALL;
                    else if (f3 == 0 && ins[31:20] == 1) r.event_kind = EV_EBREAK;
                    else ok = 1'b0;
                end
                default: ok = 1'b0;
            endcase
            if (!ok) begin
                r = '0; r.status = ST_UNSUP; npc = pc_q;
            end else begin
                if (wr && rd != 0) begin
                    gpr[rd] = wval;
                    r.reg_written = 1'b1; r.dest_index = rd; r.dest_value = wval;
                end
                pc_q = npc;
            end
        end
        r.next_pc = npc;
        return r;
    endfunction

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (!s_tvalid || s_tready) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cmd_t c;
                    c = pending_cmds.pop_front();
                    expected_results.push_back(execute_cmd(c));
                    s_tvalid <= 1'b1;
                    s_tuser <= c.is_return;
                    s_tdata <= {7'h0, c.bus_error, c.load_data, c.instruction};
                end else s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            result_t got, exp;
            got = m_tdata[$bits(result_t)-1:0];
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
            end else begin
                exp = expected_results.pop_front();
                if (got.status !== exp.status) begin
                    $error("status exp %0d got %0d", exp.status, got.status); errors++; end
                if (got.event_kind !== exp.event_kind) begin
                    $error("event_kind exp %0d got %0d", exp.event_kind, got.event_kind);
                    errors++; end
                if (got.next_pc !== exp.next_pc) begin
                    $error("next_pc exp %h got %h", exp.next_pc, got.next_pc); errors++; end
                if (got.mem_request !== exp.mem_request) begin
                    $error("mem_request exp %0d got %0d", exp.mem_request, got.mem_request);
                    errors++; end
                if (got.mem_address !== exp.mem_address) begin
                    $error("mem_address exp %h got %h", exp.mem_address, got.mem_address);
                    errors++; end
                if (got.mem_bytes !== exp.mem_bytes) begin
                    $error("mem_bytes exp %0d got %0d", exp.mem_bytes, got.mem_bytes);
                    errors++; end
                if (got.mem_write_data !== exp.mem_write_data) begin
                    $error("mem_write_data exp %h got %h", exp.mem_write_data,
                           got.mem_write_data); errors++; end
                if (got.reg_written !== exp.reg_written) begin
                    $error("reg_written exp %0d got %0d", exp.reg_written, got.reg_written);
                    errors++; end
                if (got.dest_index !== exp.dest_index) begin
                    $error("dest_index exp %0d got %0d", exp.dest_index, got.dest_index);
                    errors++; end
                if (got.dest_value !== exp.dest_value) begin
                    $error("dest_value exp %h got %h", exp.dest_value, got.dest_value);
                    errors++; end
            end
        end
    end

    function automatic cmd_t mk_exec(logic [31:0] ins);
        cmd_t c;
        c.is_return = 1'b0; c.instruction = ins;
        c.load_data = $urandom(); c.bus_error = 1'($urandom_range(1));
        return c;
    endfunction

    function automatic cmd_t mk_ret(logic [31:0] d, logic be);
        cmd_t c;
        c.is_return = 1'b1; c.instruction = $urandom();
        c.load_data = d; c.bus_error = be;
        return c;
    endfunction

    // mostly valid instructions with random registers and immediates
    function automatic logic [31:0] rand_ins();
        logic [31:0] x;
        logic [2:0]  f3;
        x = $urandom();
        f3 = x[14:12];
        case ($urandom_range(13))
            0: return {x[31:15], 3'd0, x[11:7], OPC_LOAD} | (32'(f3 % 3) << 12)
                      | (32'(x[0] & (f3 != 2)) << 14);
            1: return {x[31:15], f3, x[11:7], OPC_OPIMM};
            2: return {x[31:12], x[11:7], OPC_AUIPC};
            3: return {x[31:12], x[11:7], OPC_LUI};
            4: return {x[31:15], 1'b0, x[13:12], x[11:7], OPC_STORE};
            5, 6: return {x[31] ? F7_ALT : 7'h0, x[24:7], OPC_OP};
            7, 8: return {x[31:15], f3, x[11:7], OPC_BRANCH};
            9: return {x[31:15], 3'd0, x[11:7], OPC_JALR};
            10: return {x[31:7], OPC_JAL};
            11: return x[0] ? {x[31:15], 3'd0, x[11:7], OPC_MISC}
                            : {11'h0, x[20], 13'h0, OPC_SYSTEM};
            12: return {x[31:7], 2'b0, x[4:0]} ^ 32'(x[2:0] & 3'd1);
            default: return x;
        endcase
    endfunction

    // whether the last queued command leaves a load outstanding
    function automatic logic ld_busy_after();
        logic busy;
        busy = ld_busy;
        foreach (pending_cmds[i]) begin
            if (pending_cmds[i].is_return) busy = 1'b0;
            else if (!busy && pending_cmds[i].instruction[6:0] == OPC_LOAD) busy = 1'b1;
        end
        return busy;
    endfunction

    task automatic wait_drain();
        while (pending_cmds.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_start(logic [31:0] v);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        pc_q = v;
    endtask

    initial begin
        logic [31:0] starts[4];
        starts = '{32'h0, 32'hffff_fff0, 32'h8000_0000, 32'h0000_1000};
        foreach (gpr[i]) gpr[i] = '0;
        pc_q = '0; ld_busy = 1'b0; ld_rd = '0; ld_f3 = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        write_start(starts[0]);

        // directed
        pending_cmds.push_back(mk_ret(32'h1234_5678, 1'b0));
        pending_cmds.push_back(mk_exec({20'hfffff, 5'd1, OPC_LUI}));
        pending_cmds.push_back(mk_exec({12'hfff, 5'd1, 3'd0, 5'd2, OPC_OPIMM}));
        pending_cmds.push_back(mk_exec({12'h7ff, 5'd0, 3'd0, 5'd3, OPC_OPIMM}));
        pending_cmds.push_back(mk_exec({F7_ALT, 5'd3, 5'd2, 3'd0, 5'd4, OPC_OP}));
        pending_cmds.push_back(mk_exec({F7_ALT, 5'd3, 5'd1, 3'd5, 5'd5, OPC_OP}));
        pending_cmds.push_back(mk_exec({7'h0, 5'd31, 5'd1, 3'd5, 5'd6, OPC_OP}));
        pending_cmds.push_back(mk_exec({12'h800, 5'd1, 3'd0, 5'd7, OPC_LOAD}));
        pending_cmds.push_back(mk_exec({20'h12345, 5'd8, OPC_LUI}));
        pending_cmds.push_back(mk_ret(32'h0000_0080, 1'b0));
        pending_cmds.push_back(mk_exec({12'h0, 5'd0, 3'd4, 5'd0, OPC_LOAD}));
        pending_cmds.push_back(mk_ret(32'hffff_ffff, 1'b0));
        pending_cmds.push_back(mk_exec({12'h7ff, 5'd2, 3'd5, 5'd9, OPC_LOAD}));
        pending_cmds.push_back(mk_ret(32'hffff_ffff, 1'b1));
        pending_cmds.push_back(mk_exec({7'h7f, 5'd2, 5'd1, 3'd2, 5'h1f, OPC_STORE}));
        pending_cmds.push_back(mk_exec({1'b1, 10'h3ff, 1'b1, 8'hff, 5'd10, OPC_JAL}));
        pending_cmds.push_back(mk_exec({12'hfff, 5'd2, 3'd0, 5'd11, OPC_JALR}));
        pending_cmds.push_back(mk_exec({7'h7f, 5'd1, 5'd3, 3'd4, 5'h1f, OPC_BRANCH}));
        pending_cmds.push_back(mk_exec({12'h000, 13'h0, OPC_SYSTEM}));
        pending_cmds.push_back(mk_exec({12'h001, 13'h0, OPC_SYSTEM}));
        pending_cmds.push_back(mk_exec({12'h002, 13'h0, OPC_SYSTEM}));
        pending_cmds.push_back(mk_exec({17'h0, 3'd0, 5'd0, OPC_MISC}));
        pending_cmds.push_back(mk_exec({17'h0, 3'd1, 5'd0, OPC_MISC}));
        pending_cmds.push_back(mk_exec({7'h0, 5'd3, 5'd1, 3'd1, 5'd12, OPC_OPIMM}));
        pending_cmds.push_back(mk_exec(32'hffff_ffff));
        wait_drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 66; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 66; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            write_start(starts[ph]);
            for (int k = 0; k < 306; k++) begin
                int dice;
                dice = $urandom_range(99);
                if (ld_busy_after() && dice < 85)
                    pending_cmds.push_back(mk_ret($urandom(), $urandom_range(9) == 0));
                else if (dice < 4)
                    pending_cmds.push_back(mk_ret($urandom(), 1'($urandom_range(1))));
                else
                    pending_cmds.push_back(mk_exec(rand_ins()));
                if (k == 150) wait_drain();
            end
            wait_drain();
        end
        send_idle_pct = 0; stall_pct = 0;
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
